### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("next-cycle check failed");

`endif

### hdl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mme_pkg;
	localparam int OPERAND_BITS_DEF = 64;
	localparam int FIELD_BITS = 64;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic red_base;
		logic red_dbl;
		logic mm_start;
		logic mm_sel_sq;
		logic mm_step;
		logic fin_acc;
		logic fin_sq;
		logic out_load;
	} mme_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad;
		logic exp_zero;
		logic exp_bit;
		logic cnt_last;
		logic ks_last;
	} mme_stat_t;
endpackage

### hdl/montgomery_modular_exponent_core.sv
// ----------------------------------------------------------------------------
// montgomery_modular_exponent_core
// Modular exponentiation with a bit-serial Montgomery multiplier.
// ----------------------------------------------------------------------------
// Usage: one word on the s_ channel carries base, exponent and odd modulus;
// one word on the m_ channel returns base^exponent mod modulus, with tuser
// set when the modulus is even or below 3 (the data is then zero).
// Only the low OPERAND_BITS bits of each input field are used.
// Sequence, with k the bit length of the modulus: the base is reduced by
// modular doubling over all OPERAND_BITS bits, then doubled k more times;
// each exponent bit up to the top set one, lowest first, takes a squaring,
// preceded by a multiply into the accumulator when the bit is set; then the
// result is handed off. Every product goes through the one Montgomery unit,
// which retires one bit per cycle. A bad modulus skips to the hand-off.
// Items are handled one at a time; s_tready is high only while idle.
// The result sits in an output register, so the next word is taken while
// a result still waits; if the receiver stalls with a result pending, the
// finished item holds until that register frees up.
// Reset clears the sequencer and the output valid; no results are pending.
// ----------------------------------------------------------------------------
module montgomery_modular_exponent_core #(
	parameter int OPERAND_BITS = mme_pkg::OPERAND_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // base_value, exponent_value, modulus_value
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // power_result
	output logic         m_tuser   // bad_modulus
);
	import mme_pkg::*;

	mme_cmd_t              cmd;
	mme_stat_t             stat;
	logic [OPERAND_BITS-1:0] res;

	mme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.stat      (stat)
	);

	mme_dp #(.W(OPERAND_BITS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.in_base (s_tdata[OPERAND_BITS-1:0]),
		.in_exp  (s_tdata[FIELD_BITS+OPERAND_BITS-1:FIELD_BITS]),
		.in_mod  (s_tdata[2*FIELD_BITS+OPERAND_BITS-1:2*FIELD_BITS]),
		.res     (res),
		.res_bad (m_tuser)
	);

	assign m_tdata = FIELD_BITS'(res);
endmodule

### hdl/mme_dp.sv
// ----------------------------------------------------------------------------
// mme_dp
// Operand registers, modular doubling unit and bit-serial Montgomery unit.
// ----------------------------------------------------------------------------
module mme_dp #(
	parameter int W = mme_pkg::OPERAND_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mme_pkg::mme_cmd_t               cmd,
	output mme_pkg::mme_stat_t              stat,
	input  logic [W-1:0]                    in_base,
	input  logic [W-1:0]                    in_exp,
	input  logic [W-1:0]                    in_mod,
	output logic [W-1:0]                    res,
	output logic                            res_bad
);
	import mme_pkg::*;

	localparam int CW = $clog2(W);

	logic [W-1:0]  base_q, exp_q, mod_q, a_q, acc_q, xs_q, y_q, ks_q, res_q;
	logic [W:0]    t_q;
	logic [CW-1:0] cnt_q;
	logic          bad_q;

	logic          red_bit;
	logic [W:0]    red_v, red_s;
	logic [W-1:0]  red_next;
	logic [W+1:0]  mm_s1, mm_s2;
	logic [W:0]    fin_s;
	logic [W-1:0]  fin_val;

	// Modular doubling: shift in one base bit, subtract the modulus once.
	always_comb begin
		red_bit  = cmd.red_base & base_q[W-1];
		red_v    = {a_q, red_bit};
		red_s    = red_v - {1'b0, mod_q};
		red_next = (red_v >= {1'b0, mod_q}) ? red_s[W-1:0] : red_v[W-1:0];
	end

	// One radix-2 Montgomery step and the final correction.
	always_comb begin
		mm_s1   = {1'b0, t_q} + (xs_q[0] ? {2'b00, y_q} : '0);
		mm_s2   = mm_s1 + (mm_s1[0] ? {2'b00, mod_q} : '0);
		fin_s   = t_q - {1'b0, mod_q};
		fin_val = (t_q >= {1'b0, mod_q}) ? fin_s[W-1:0] : t_q[W-1:0];
	end

	// Status back to the controller.
	always_comb begin
		stat.bad      = ~mod_q[0] | (mod_q < W'(3));
		stat.exp_zero = (exp_q == '0);
		stat.exp_bit  = exp_q[0];
		stat.cnt_last = (cnt_q == CW'(W-1));
		stat.ks_last  = (ks_q[W-1:1] == '0);
	end

	// Operand and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			exp_q  <= '0;
			mod_q  <= '0;
			a_q    <= '0;
			acc_q  <= '0;
			xs_q   <= '0;
			y_q    <= '0;
			ks_q   <= '0;
			res_q  <= '0;
			t_q    <= '0;
			cnt_q  <= '0;
			bad_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				base_q <= in_base;
				exp_q  <= in_exp;
				mod_q  <= in_mod;
				ks_q   <= in_mod;
				a_q    <= '0;
				acc_q  <= W'(1);
				cnt_q  <= '0;
			end
			if (cmd.red_base) begin
				a_q    <= red_next;
				base_q <= {base_q[W-2:0], 1'b0};
				cnt_q  <= cnt_q + CW'(1);
			end
			if (cmd.red_dbl) begin
				a_q  <= red_next;
				ks_q <= ks_q >> 1;
			end
			if (cmd.mm_start) begin
				t_q  <= '0;
				xs_q <= a_q;
				y_q  <= cmd.mm_sel_sq ? a_q : acc_q;
				ks_q <= mod_q;
			end
			if (cmd.mm_step) begin
				t_q  <= mm_s2[W+1:1];
				xs_q <= xs_q >> 1;
				ks_q <= ks_q >> 1;
			end
			if (cmd.fin_acc)
				acc_q <= fin_val;
			if (cmd.fin_sq) begin
				a_q   <= fin_val;
				exp_q <= exp_q >> 1;
			end
			if (cmd.out_load) begin
				res_q <= stat.bad ? '0 : acc_q;
				bad_q <= stat.bad;
			end
		end
	end

	assign res     = res_q;
	assign res_bad = bad_q;
endmodule

### hdl/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Sequencer for setup, doubling and the exponent scan; owns the handshakes.
// ----------------------------------------------------------------------------
module mme_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mme_pkg::mme_cmd_t  cmd,
	input  mme_pkg::mme_stat_t stat
);
	import mme_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_RBASE = 4'd2;
	localparam logic [3:0] S_RDBL = 4'd3;
	localparam logic [3:0] S_EXP = 4'd4;
	localparam logic [3:0] S_MACC = 4'd5;
	localparam logic [3:0] S_FACC = 4'd6;
	localparam logic [3:0] S_MSQ = 4'd7;
	localparam logic [3:0] S_FSQ = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0] state_q, state_d;
	logic       valid_q;
	logic       out_free;

	assign out_free  = ~valid_q | out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = valid_q;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: state_d = stat.bad ? S_DONE : S_RBASE;
			S_RBASE: begin
				cmd.red_base = 1'b1;
				if (stat.cnt_last)
					state_d = S_RDBL;
			end
			S_RDBL: begin
				cmd.red_dbl = 1'b1;
				if (stat.ks_last)
					state_d = S_EXP;
			end
			S_EXP: begin
				if (stat.exp_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.mm_start  = 1'b1;
					cmd.mm_sel_sq = ~stat.exp_bit;
					state_d       = stat.exp_bit ? S_MACC : S_MSQ;
				end
			end
			S_MACC: begin
				cmd.mm_step = 1'b1;
				if (stat.ks_last)
					state_d = S_FACC;
			end
			S_FACC: begin
				cmd.fin_acc   = 1'b1;
				cmd.mm_start  = 1'b1;
				cmd.mm_sel_sq = 1'b1;
				state_d       = S_MSQ;
			end
			S_MSQ: begin
				cmd.mm_step = 1'b1;
				if (stat.ks_last)
					state_d = S_FSQ;
			end
			S_FSQ: begin
				cmd.fin_sq = 1'b1;
				state_d    = S_EXP;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end
endmodule

### hdl/mme_chk.sv
// ----------------------------------------------------------------------------
// mme_chk
// Port-level checks for the exponentiation core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mme_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [63:0]  m_tdata,
	input logic         m_tuser
);
	// A result that is held back stays offered.
	`ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// A stalled result keeps its data.
	`ASSERT_NEXT(a_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	// A bad modulus always returns zero.
	`ASSERT_IMPLY(a_badzero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 64'd0)
	// Once a word is taken the core is busy on it.
	`ASSERT_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
endmodule

bind montgomery_modular_exponent_core mme_chk u_mme_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### dv/tb_montgomery_modular_exponent_core.sv
// ----------------------------------------------------------------------------
// tb_montgomery_modular_exponent_core
// Self-checking testbench for the Montgomery modular exponentiation core.
// ----------------------------------------------------------------------------
// Words carrying a base, an exponent and a modulus are fed from a queue of
// pending items, with random gaps. Each accepted word is matched against a
// square-and-multiply model that runs on 128-bit intermediates. The receiver
// stalls at random and once holds off for a long stretch. Most words use
// short moduli and exponents to keep the run short. A few use full width.
// ----------------------------------------------------------------------------
module tb_montgomery_modular_exponent_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] base_value;
		logic [63:0] exponent_value;
		logic [63:0] modulus_value;
		int          gap;
		bit          drain;
	} operand_set_t;

	typedef struct {
		logic [63:0] power_result;
		logic        bad_modulus;
	} power_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic         m_tuser;

	operand_set_t pending_sets[$];
	power_t       expected_powers[$];
	operand_set_t current_set;
	bit           offering = 1'b0;
	bit           loaded = 1'b0;
	int           gap_left = 0;
	int           error_count = 0;
	int           results_seen = 0;
	int           hold_left = 0;
	longint       cycle_count = 0;
	longint       cycle_limit = 64'd100000000;

	montgomery_modular_exponent_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Expected power by plain square-and-multiply on wide intermediates.
	function automatic power_t modular_power(logic [63:0] b, logic [63:0] e, logic [63:0] m);
		power_t       r;
		logic [127:0] acc;
		logic [127:0] sq;
		if (m[0] == 1'b0 || m < 64'd3) begin
			r.power_result = '0;
			r.bad_modulus = 1'b1;
			return r;
		end
		acc = 128'd1;
		sq = {64'd0, b} % {64'd0, m};
		for (int i = 0; i < 64; i++) begin
			if (e[i])
				acc = (acc * sq) % {64'd0, m};
			sq = (sq * sq) % {64'd0, m};
		end
		r.power_result = acc[63:0];
		r.bad_modulus = 1'b0;
		return r;
	endfunction

	// Worst-case cycle estimate for one word, from its modulus and exponent lengths.
	function automatic longint word_cost(operand_set_t s);
		int k;
		int n;
		k = 0;
		n = 0;
		for (int i = 0; i < 64; i++) begin
			if (s.modulus_value[i])
				k = i + 1;
			if (s.exponent_value[i])
				n = i + 1;
		end
		if (s.modulus_value[0] == 1'b0 || s.modulus_value < 64'd3)
			return 10;
		return 64 + k + 3 + n * (2 * k + 3) + 2;
	endfunction

	function automatic logic [63:0] random_word(int bits);
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		if (bits < 64)
			v = v & ((64'd1 << bits) - 64'd1);
		return v;
	endfunction

	task automatic add_set(logic [63:0] b, logic [63:0] e, logic [63:0] m, int gap, bit drain);
		operand_set_t s;
		s.base_value = b;
		s.exponent_value = e;
		s.modulus_value = m;
		s.gap = gap;
		s.drain = drain;
		pending_sets.push_back(s);
	endtask

	// Driver: presents one word at a time after its gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (offering && s_tready) begin
				expected_powers.push_back(modular_power(current_set.base_value,
					current_set.exponent_value, current_set.modulus_value));
				offering = 1'b0;
			end
			if (!offering) begin
				if (!loaded && pending_sets.size() > 0) begin
					current_set = pending_sets.pop_front();
					gap_left = current_set.gap;
					loaded = 1'b1;
				end
				if (loaded) begin
					if (gap_left > 0)
						gap_left--;
					else if (!current_set.drain || expected_powers.size() == 0) begin
						offering = 1'b1;
						loaded = 1'b0;
					end
				end
			end
			s_tvalid <= offering;
			s_tdata <= {current_set.modulus_value, current_set.exponent_value,
				current_set.base_value};
		end
	end

	// Monitor: checks each result word and draws the next stall.
	always @(posedge clk) begin
		power_t exp_word;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_powers.size() == 0) begin
					$error("unexpected result word: power_result %h bad_modulus %b",
						m_tdata, m_tuser);
					error_count++;
				end else begin
					exp_word = expected_powers.pop_front();
					if (m_tdata !== exp_word.power_result) begin
						$error("power_result: expected %h, actual %h",
							exp_word.power_result, m_tdata);
						error_count++;
					end
					if (m_tuser !== exp_word.bad_modulus) begin
						$error("bad_modulus: expected %b, actual %b",
							exp_word.bad_modulus, m_tuser);
						error_count++;
					end
				end
				results_seen++;
				if (results_seen == 60)
					hold_left = 3000;
				else if (results_seen >= 300 && results_seen < 400)
					hold_left = 0;
				else
					hold_left = $urandom_range(0, 19);
			end else if (hold_left > 0) begin
				hold_left--;
			end
			m_tready <= (hold_left == 0);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		longint budget;
		int kb;
		int nb;
		int gap;
		logic [63:0] m;
		logic [63:0] e;
		logic [63:0] all_ones;

		all_ones = '1;

		// Directed words: extremes and each special case.
		add_set(64'd0, 64'd5, 64'd13, 0, 1'b0);
		add_set(64'd7, 64'd0, 64'd13, 0, 1'b0);
		add_set(all_ones, 64'd0, all_ones, 0, 1'b0);
		add_set(64'd5, 64'd3, 64'd0, 0, 1'b0);
		add_set(64'd5, 64'd3, 64'd1, 0, 1'b0);
		add_set(64'd5, 64'd3, 64'd2, 0, 1'b0);
		add_set(all_ones, all_ones, all_ones - 64'd1, 0, 1'b0);
		add_set(64'd2, 64'd9, 64'd3, 0, 1'b0);
		add_set(64'd13, 64'd4, 64'd13, 0, 1'b0);
		add_set(64'd12, 64'd1, 64'd13, 0, 1'b0);
		add_set(64'd1, all_ones, 64'd101, 0, 1'b0);
		add_set(all_ones, all_ones, all_ones, 3, 1'b0);
		add_set(all_ones, 64'd65537, 64'h8000_0000_0000_0001, 0, 1'b0);
		add_set(64'h1234_5678_9abc_def0, 64'd1, 64'hffff_ffff_ffff_ffc5, 0, 1'b0);
		add_set(64'd0, 64'd0, 64'd3, 0, 1'b0);
		add_set(64'd3, 64'd255, 64'd255, 5, 1'b1);
		add_set(all_ones, all_ones, 64'h8000_0000_0000_0000, 0, 1'b0);

		// Random words: mostly short operands, a few full width.
		for (int i = 0; i < 900; i++) begin
			if ($urandom_range(0, 99) < 5)
				kb = 64;
			else if ($urandom_range(0, 99) < 10)
				kb = $urandom_range(17, 63);
			else
				kb = $urandom_range(2, 16);
			m = random_word(kb);
			if (kb < 64)
				m[kb - 1] = 1'b1;
			else
				m[63] = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 99) < 90)
				m[0] = 1'b1;
			nb = ($urandom_range(0, 99) < 5) ? 64 : $urandom_range(0, 16);
			e = (nb == 0) ? 64'd0 : random_word(nb);
			if (i >= 100 && i < 200)
				gap = 0;
			else
				gap = $urandom_range(0, 19);
			add_set(random_word(64), e, m, gap, (i == 450));
		end

		budget = 0;
		foreach (pending_sets[j])
			budget += word_cost(pending_sets[j]) + 40;
		cycle_limit = 4 * budget + 50000;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_sets.size() > 0 || offering || loaded || expected_powers.size() > 0);
		repeat (200) @(posedge clk);

		if (error_count == 0 && expected_powers.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
